>>> src/glcm_pkg.sv
package glcm_pkg;

	// Sizes of the matrix, the line buffer and the counts.
	localparam int GRAY_LEVELS = 256;
	localparam int MAX_WIDTH   = 1024;
	localparam int COUNT_BITS  = 32;

	localparam int LEVEL_BITS = $clog2(GRAY_LEVELS);
	localparam int COL_BITS   = $clog2(MAX_WIDTH);
	localparam int COL_EXT    = COL_BITS + 1;
	localparam int CNT_DEPTH  = GRAY_LEVELS * GRAY_LEVELS;
	localparam int CNT_AW     = $clog2(CNT_DEPTH);

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

	// Neighbour directions.
	localparam logic [1:0] DIR_0   = 2'd0;
	localparam logic [1:0] DIR_45  = 2'd1;
	localparam logic [1:0] DIR_90  = 2'd2;
	localparam logic [1:0] DIR_135 = 2'd3;

	// Operation codes.
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	// Highest gray level, at the width of the pixel field.
	localparam logic [7:0] TOP_LEVEL = 8'(GRAY_LEVELS - 1);

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] pixel_level;
		logic [7:0] query_first;
		logic [7:0] query_second;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pair_count;
		logic        frame_done;
		logic        status_code;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic up_capture;
		logic commit;
		logic cnt_rd_a;
		logic cnt_wr_a;
		logic cnt_rd_b;
		logic cnt_wr_b;
		logic query_rd;
		logic sweep;
		logic emit;
	} glcm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic frame_full;
		logic pair_hit;
		logic sweep_last;
		logic out_free;
	} glcm_sts_t;

endpackage

>>> src/glcm_ram.sv
module glcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/glcm_ctrl.sv
module glcm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            in_op,
	input  glcm_pkg::glcm_sts_t   sts,
	output glcm_pkg::glcm_cmd_t   cmd
);

	import glcm_pkg::*;

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_LB_UP  = 4'd2;
	localparam logic [3:0] S_LB_UR  = 4'd3;
	localparam logic [3:0] S_CNT_RA = 4'd4;
	localparam logic [3:0] S_CNT_WA = 4'd5;
	localparam logic [3:0] S_CNT_RB = 4'd6;
	localparam logic [3:0] S_CNT_WB = 4'd7;
	localparam logic [3:0] S_QUERY  = 4'd8;
	localparam logic [3:0] S_CLEAR  = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// Items are taken only while the controller waits in idle.
	assign in_stall = (state_q != S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (in_op)
						OP_PUSH:  state_d = sts.frame_full ? S_DONE : S_LB_UP;
						OP_READ:  state_d = S_QUERY;
						OP_CLEAR: state_d = S_CLEAR;
						OP_NOP:   state_d = S_DONE;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_LB_UP: begin
				cmd.up_capture = 1'b1;
				state_d = S_LB_UR;
			end
			S_LB_UR: begin
				cmd.commit = 1'b1;
				state_d = sts.pair_hit ? S_CNT_RA : S_DONE;
			end
			S_CNT_RA: begin
				cmd.cnt_rd_a = 1'b1;
				state_d = S_CNT_WA;
			end
			S_CNT_WA: begin
				cmd.cnt_wr_a = 1'b1;
				state_d = S_CNT_RB;
			end
			S_CNT_RB: begin
				cmd.cnt_rd_b = 1'b1;
				state_d = S_CNT_WB;
			end
			S_CNT_WB: begin
				cmd.cnt_wr_b = 1'b1;
				state_d = S_DONE;
			end
			S_QUERY: begin
				cmd.query_rd = 1'b1;
				state_d = S_DONE;
			end
			S_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> src/glcm_dpath.sv
module glcm_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [glcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [glcm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  glcm_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output glcm_pkg::out_item_t              out_data,
	input  glcm_pkg::glcm_cmd_t              cmd,
	output glcm_pkg::glcm_sts_t              sts
);

	import glcm_pkg::*;

	// Configuration registers.
	logic [1:0]  dir_q;
	logic [10:0] fw_q;
	logic [15:0] fh_q;

	// Raster position and neighbour registers.
	logic [COL_BITS-1:0]   col_q;
	logic [15:0]           row_q;
	logic [LEVEL_BITS-1:0] left_q;
	logic [LEVEL_BITS-1:0] upleft_q;
	logic [LEVEL_BITS-1:0] up_q;

	// Current item.
	logic [1:0]            op_q;
	logic [LEVEL_BITS-1:0] cur_q;
	logic [LEVEL_BITS-1:0] qa_q;
	logic [LEVEL_BITS-1:0] qb_q;
	logic                  q_ok_q;
	logic [LEVEL_BITS-1:0] nb_q;
	logic                  frame_done_q;
	logic                  status_q;

	logic [CNT_AW-1:0] sweep_q;
	logic              out_valid_q;
	out_item_t         out_data_q;

	logic [COL_EXT-1:0]    eff_w;
	logic [15:0]           eff_h;
	logic [COL_EXT-1:0]    col_inc;
	logic                  row_wrap;
	logic [15:0]           row_inc;
	logic [COL_BITS-1:0]   ur_addr;
	logic [LEVEL_BITS-1:0] cur_d;
	logic                  pair_hit;
	logic [LEVEL_BITS-1:0] nb_d;

	logic [LEVEL_BITS-1:0] lb_rdata;
	logic                  lb_re;
	logic [COL_BITS-1:0]   lb_raddr;

	logic [COUNT_BITS-1:0] cnt_rdata;
	logic [COUNT_BITS-1:0] cnt_sat;
	logic                  cnt_we;
	logic [CNT_AW-1:0]     cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic                  cnt_re;
	logic [CNT_AW-1:0]     cnt_raddr;
	logic [CNT_AW-1:0]     addr_a;
	logic [CNT_AW-1:0]     addr_b;
	logic [CNT_AW-1:0]     addr_q;
	logic                  sweep_last;

	function automatic logic [CNT_AW-1:0] pair_addr(input logic [LEVEL_BITS-1:0] a,
			input logic [LEVEL_BITS-1:0] b);
		return CNT_AW'(a) * CNT_AW'(GRAY_LEVELS) + CNT_AW'(b);
	endfunction

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_0;
			fw_q  <= 11'd1024;
			fh_q  <= 16'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIRECTION: dir_q <= cfg_data[1:0];
				REG_WIDTH:     fw_q  <= cfg_data[10:0];
				REG_HEIGHT:    fh_q  <= cfg_data[15:0];
				default:       ;
			endcase
		end
	end

	// Effective frame size: zero acts as one, width capped at the line buffer.
	always_comb begin
		if (fw_q == '0) begin
			eff_w = COL_EXT'(1);
		end else if (int'(fw_q) > MAX_WIDTH) begin
			eff_w = COL_EXT'(MAX_WIDTH);
		end else begin
			eff_w = COL_EXT'(fw_q);
		end
		eff_h = (fh_q == '0) ? 16'd1 : fh_q;
	end

	assign col_inc  = COL_EXT'(col_q) + COL_EXT'(1);
	assign row_wrap = (col_inc >= eff_w);
	assign row_inc  = row_q + 16'd1;
	assign ur_addr  = (col_q == COL_BITS'(MAX_WIDTH - 1)) ? '0 : col_q + COL_BITS'(1);
	assign cur_d    = (in_data.pixel_level > TOP_LEVEL) ? TOP_LEVEL[LEVEL_BITS-1:0]
	                                                    : in_data.pixel_level[LEVEL_BITS-1:0];

	// Neighbour choice; the upper-right pixel is on the line buffer read port.
	always_comb begin
		unique case (dir_q)
			DIR_0: begin
				pair_hit = (col_q != '0);
				nb_d     = left_q;
			end
			DIR_45: begin
				pair_hit = (row_q != '0) && (col_q != '0);
				nb_d     = upleft_q;
			end
			DIR_90: begin
				pair_hit = (row_q != '0);
				nb_d     = up_q;
			end
			DIR_135: begin
				pair_hit = (row_q != '0) && !row_wrap;
				nb_d     = lb_rdata;
			end
			default: begin
				pair_hit = 1'b0;
				nb_d     = left_q;
			end
		endcase
	end

	// Raster position and neighbour history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
			upleft_q <= '0;
		end else if (cmd.accept && (in_data.operation == OP_CLEAR)) begin
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
			upleft_q <= '0;
		end else if (cmd.commit) begin
			upleft_q <= up_q;
			left_q   <= cur_q;
			if (row_wrap) begin
				col_q <= '0;
				row_q <= row_inc;
			end else begin
				col_q <= col_inc[COL_BITS-1:0];
			end
		end
	end

	// Item and result payload.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q         <= in_data.operation;
			cur_q        <= cur_d;
			qa_q         <= in_data.query_first[LEVEL_BITS-1:0];
			qb_q         <= in_data.query_second[LEVEL_BITS-1:0];
			q_ok_q       <= (int'(in_data.query_first) < GRAY_LEVELS) &&
			                (int'(in_data.query_second) < GRAY_LEVELS);
			frame_done_q <= 1'b0;
			status_q     <= (in_data.operation == OP_PUSH) && sts.frame_full;
		end
		if (cmd.up_capture) begin
			up_q <= lb_rdata;
		end
		if (cmd.commit) begin
			nb_q         <= nb_d;
			frame_done_q <= row_wrap && (row_inc >= eff_h);
		end
	end

	// Line buffer: the pixel above at accept, the one above-right next.
	assign lb_re    = cmd.accept || cmd.up_capture;
	assign lb_raddr = cmd.up_capture ? ur_addr : col_q;

	glcm_ram #(
		.WIDTH(LEVEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk  (clk),
		.we   (cmd.commit),
		.waddr(col_q),
		.wdata(cur_q),
		.re   (lb_re),
		.raddr(lb_raddr),
		.rdata(lb_rdata)
	);

	// Count store: clearing sweep, two saturating increments, or a query.
	assign addr_a     = pair_addr(cur_q, nb_q);
	assign addr_b     = pair_addr(nb_q, cur_q);
	assign addr_q     = pair_addr(qa_q, qb_q);
	assign sweep_last = (sweep_q == CNT_AW'(CNT_DEPTH - 1));
	assign cnt_sat    = (&cnt_rdata) ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);
	assign cnt_we     = cmd.sweep || cmd.cnt_wr_a || cmd.cnt_wr_b;
	assign cnt_waddr  = cmd.sweep ? sweep_q : (cmd.cnt_wr_a ? addr_a : addr_b);
	assign cnt_wdata  = cmd.sweep ? '0 : cnt_sat;
	assign cnt_re     = cmd.cnt_rd_a || cmd.cnt_rd_b || cmd.query_rd;
	assign cnt_raddr  = cmd.cnt_rd_a ? addr_a : (cmd.cnt_rd_b ? addr_b : addr_q);

	glcm_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(CNT_DEPTH)
	) u_count_mem (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.re   (cnt_re),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	// Sweep address, back at zero after the last entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= sweep_last ? '0 : sweep_q + CNT_AW'(1);
		end
	end

	// Output register; a query result is still held on the count read port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q.pair_count  <= ((op_q == OP_READ) && q_ok_q) ? 32'(cnt_rdata) : '0;
			out_data_q.frame_done  <= frame_done_q;
			out_data_q.status_code <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Status towards the controller.
	assign sts.frame_full = (row_q >= eff_h);
	assign sts.pair_hit   = pair_hit;
	assign sts.sweep_last = sweep_last;
	assign sts.out_free   = !out_valid_q || !out_stall;

endmodule

>>> src/gray_cooccurrence_matrix.sv
// Symmetric gray-level co-occurrence matrix for one direction. Pixels are
// pushed in raster order; each pixel with an earlier neighbour in the chosen
// direction adds one to both [pixel][neighbour] and [neighbour][pixel] in a
// 256 x 256 store of saturating 32-bit counts. One beat goes in and one result
// beat comes out per item, and the block works on one item at a time. A push
// that counts a pair makes two line-buffer reads, then a read and a write of
// the count memory for each of the two entries; a read makes one count read.
// A clear, and reset itself, sweep the count memory one entry a cycle; no item
// is accepted during the sweep, though configuration writes are taken.
// Configuration should only be written while the block is idle.
module gray_cooccurrence_matrix (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [glcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [glcm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  glcm_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output glcm_pkg::out_item_t              out_data
);

	import glcm_pkg::*;

	glcm_cmd_t cmd;
	glcm_sts_t sts;

	// Sequencing of each item.
	glcm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_op   (in_data.operation),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Line buffer, count store, position and output register.
	glcm_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
